// ===== rtl/plob_pkg.sv =====
// Shared types, codes and constants of the price level order book.
// Used by the top level; no dependencies.
package plob_pkg;

    localparam int WINDOW     = 4096;
    localparam int HALF_WIN   = WINDOW / 2;
    localparam int CAP        = 16384;
    localparam int LEVELS     = 2 * WINDOW;
    localparam int OCC_W      = 64;
    localparam int NWORDS     = (LEVELS + OCC_W - 1) / OCC_W;
    localparam int SLOT_W     = $clog2(CAP);
    localparam int CNT_W      = $clog2(CAP + 1);
    localparam int LVL_W      = $clog2(LEVELS);
    localparam int WIDX_W     = LVL_W - 6;
    localparam int ORD_W      = $clog2(CAP + 1);
    localparam int TOT_W      = 48;
    localparam int CLR_N      = (CAP > LEVELS) ? CAP : LEVELS;
    localparam int CLR_W      = $clog2(CLR_N);
    localparam int Q_W        = 26;
    localparam int PRICE_STEP = 100;
    localparam longint DIV_RECIP = 64'd1374389535;
    localparam int DIV_SHIFT  = 37;

    typedef enum logic [2:0] {
        MODE_ADD     = 3'd0,
        MODE_EXECUTE = 3'd1,
        MODE_CANCEL  = 3'd2,
        MODE_DELETE  = 3'd3,
        MODE_REPLACE = 3'd4
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_UNKNOWN = 2'd1,
        ST_FULL    = 2'd2,
        ST_RANGE   = 2'd3
    } t_status;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_DIV, S_REM, S_FIND, S_EX_RD, S_EX_WR, S_RM_RD, S_RM_WR,
        S_SCAN_RD, S_SCAN_CK, S_PICK, S_POP, S_PL_RD, S_PL_WR, S_PRICE, S_DONE
    } t_state;

    typedef struct packed {
        logic [2:0]  mode;
        logic [63:0] msg_ref;
        logic [63:0] new_ref;
        logic [31:0] price;
        logic        is_sell;
        logic [31:0] shares;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic        bid_valid;
        logic [31:0] best_bid_price;
        logic        ask_valid;
        logic [31:0] best_ask_price;
    } t_out_item;

    typedef struct packed {
        logic             valid;
        logic [63:0]      oref;
        logic [31:0]      qty;
        logic [LVL_W-1:0] lvl;
    } t_slot_ent;

    typedef struct packed {
        logic [ORD_W-1:0] orders;
        logic [TOT_W-1:0] total;
    } t_lvl_ent;

    function automatic logic [5:0] f_top_bit(input logic [OCC_W-1:0] w);
        logic [5:0] n;
        n = '0;
        for (int i = 0; i < OCC_W; i++) begin
            if (w[i]) n = 6'(i);
        end
        return n;
    endfunction

    function automatic logic [5:0] f_low_bit(input logic [OCC_W-1:0] w);
        logic [5:0] n;
        n = '0;
        for (int i = OCC_W - 1; i >= 0; i--) begin
            if (w[i]) n = 6'(i);
        end
        return n;
    endfunction

endpackage

// ===== rtl/plob_ram.sv =====
// Simple dual-port synchronous RAM, one write and one registered read port.
// Generic; no package dependency.
module plob_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end
endmodule

// ===== rtl/price_level_order_book.sv =====
// Price level order book: one transaction in, one status/best-price transaction out.
// Lookups scan the slot RAM, 1 slot a cycle, from slot 0 until a hit or the last slot.
// Emptying the best level adds a bitmap rescan that reads and checks one 64-level word at a time.
// Throughput: one transaction at a time; the next is taken once the result is registered.
// Reset: synchronous, active low; then a clearing pass over CLR_N (16384) addresses initializes
// the slot, free-stack, level and bitmap RAMs while input is stalled.
module price_level_order_book (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  plob_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output plob_pkg::t_out_item o_out_item
);
    import plob_pkg::*;

    // Control
    t_state r_state, n_state;
    t_in_item r_in;
    t_status r_status;
    logic [Q_W-1:0] r_q;
    logic r_rem_nz;
    logic [32:0] r_base;
    logic r_base_known;
    logic [CNT_W-1:0] r_fc;
    logic r_bid_ok, r_ask_ok;
    logic [LVL_W-1:0] r_bid_lvl, r_ask_lvl, r_lvl;
    logic [SLOT_W-1:0] r_slot, r_rd_addr;
    t_slot_ent r_ent;
    logic r_side;
    logic [CNT_W-1:0] r_scan;
    logic r_rd_pend;
    logic [WIDX_W-1:0] r_sw;
    logic [5:0] r_sb;
    logic r_sfirst, r_sdn;
    logic [CLR_W-1:0] r_clr;
    logic [31:0] r_bid_price, r_ask_price;
    t_out_item r_out;
    logic r_out_valid;

    // Memory ports
    logic slot_we, lvl_we, occ_we, stk_we;
    logic [SLOT_W-1:0] slot_wa, slot_ra, stk_wa, stk_ra, stk_wd, stk_rd;
    t_slot_ent slot_wd, s_rd;
    logic [LVL_W-1:0] lvl_wa, lvl_ra;
    t_lvl_ent lvl_wd, lv_rd;
    logic [WIDX_W-1:0] occ_wa, occ_ra;
    logic [OCC_W-1:0] occ_wd, occ_rd;

    plob_ram #(.WIDTH($bits(t_slot_ent)), .DEPTH(CAP)) u_slot_ram (
        .i_clk(i_clk), .i_wr_en(slot_we), .i_wr_addr(slot_wa), .i_wr_data(slot_wd),
        .i_rd_addr(slot_ra), .o_rd_data(s_rd)
    );
    plob_ram #(.WIDTH(SLOT_W), .DEPTH(CAP)) u_stack_ram (
        .i_clk(i_clk), .i_wr_en(stk_we), .i_wr_addr(stk_wa), .i_wr_data(stk_wd),
        .i_rd_addr(stk_ra), .o_rd_data(stk_rd)
    );
    plob_ram #(.WIDTH($bits(t_lvl_ent)), .DEPTH(LEVELS)) u_level_ram (
        .i_clk(i_clk), .i_wr_en(lvl_we), .i_wr_addr(lvl_wa), .i_wr_data(lvl_wd),
        .i_rd_addr(lvl_ra), .o_rd_data(lv_rd)
    );
    plob_ram #(.WIDTH(OCC_W), .DEPTH(NWORDS)) u_occ_ram (
        .i_clk(i_clk), .i_wr_en(occ_we), .i_wr_addr(occ_wa), .i_wr_data(occ_wd),
        .i_rd_addr(occ_ra), .o_rd_data(occ_rd)
    );

    // Lookup hit: the slot read issued in the previous cycle holds the wanted reference
    logic slot_hit, not_found;
    assign slot_hit  = r_rd_pend && s_rd.valid && (s_rd.oref == r_in.msg_ref);
    assign not_found = !r_rd_pend && (r_scan == CNT_W'(CAP));

    // Price window: the first pick fixes the base, centered on that price
    logic [32:0] eff_base;
    logic [33:0] off34;
    logic pick_ok;
    logic [LVL_W-1:0] pick_lvl;
    assign eff_base = r_base_known ? r_base : (33'(r_q) - 33'(HALF_WIN));
    assign off34    = 34'(r_q) - {eff_base[32], eff_base};
    assign pick_ok  = !r_rem_nz && !off34[33] && (off34 < 34'(WINDOW));
    assign pick_lvl = r_side ? (LVL_W'(WINDOW) + off34[LVL_W-1:0]) : off34[LVL_W-1:0];

    // Level removal: count drops; rescan when the best level empties
    logic [ORD_W-1:0] rm_orders;
    logic rm_empty, rm_best;
    logic [OCC_W-1:0] lvl_bit;
    assign rm_orders = lv_rd.orders - ORD_W'(1);
    assign rm_empty  = (rm_orders == '0);
    assign rm_best   = rm_empty && ((r_bid_ok && r_lvl == r_bid_lvl) ||
                                    (r_ask_ok && r_lvl == r_ask_lvl));
    assign lvl_bit   = OCC_W'(1) << r_lvl[5:0];

    // Bitmap scan: mask the first word at the starting bit, then take whole words
    logic [OCC_W-1:0] scan_mask, scan_word;
    logic scan_hit;
    always_comb begin
        if (!r_sfirst) begin
            scan_mask = '1;
        end else if (r_sdn) begin
            scan_mask = {OCC_W{1'b1}} >> (6'd63 - r_sb);
        end else begin
            scan_mask = {OCC_W{1'b1}} << r_sb;
        end
    end
    assign scan_word = occ_rd & scan_mask;
    assign scan_hit  = (scan_word != '0);

    logic is_exec, post_rm_pick;
    assign is_exec      = (r_in.mode == MODE_EXECUTE) || (r_in.mode == MODE_CANCEL);
    assign post_rm_pick = (r_in.mode == MODE_REPLACE);

    // Next state and memory control
    always_comb begin
        n_state = r_state;
        slot_we = 1'b0;
        slot_wa = r_slot;
        slot_wd = r_ent;
        slot_ra = r_scan[SLOT_W-1:0];
        stk_we  = 1'b0;
        stk_wa  = r_fc[SLOT_W-1:0];
        stk_wd  = r_slot;
        stk_ra  = SLOT_W'(r_fc - CNT_W'(1));
        lvl_we  = 1'b0;
        lvl_wa  = r_lvl;
        lvl_wd  = lv_rd;
        lvl_ra  = r_lvl;
        occ_we  = 1'b0;
        occ_wa  = r_lvl[LVL_W-1:6];
        occ_wd  = occ_rd;
        occ_ra  = r_lvl[LVL_W-1:6];
        case (r_state)
            S_CLEAR: begin
                slot_we = 1'b1;
                slot_wa = r_clr[SLOT_W-1:0];
                slot_wd = '0;
                stk_we  = 1'b1;
                stk_wa  = r_clr[SLOT_W-1:0];
                stk_wd  = SLOT_W'(CAP - 1) - r_clr[SLOT_W-1:0];
                lvl_we  = 1'b1;
                lvl_wa  = r_clr[LVL_W-1:0];
                lvl_wd  = '0;
                occ_we  = 1'b1;
                occ_wa  = r_clr[WIDX_W-1:0];
                occ_wd  = '0;
                if (r_clr == CLR_W'(CLR_N - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) n_state = S_DIV;
            end
            S_DIV: n_state = S_REM;
            S_REM: begin
                case (r_in.mode)
                    MODE_ADD:     n_state = (r_fc == '0) ? S_PRICE : S_PICK;
                    MODE_EXECUTE,
                    MODE_CANCEL,
                    MODE_DELETE,
                    MODE_REPLACE: n_state = S_FIND;
                    default:      n_state = S_PRICE;
                endcase
            end
            S_FIND: begin
                if (slot_hit) begin
                    n_state = (is_exec && r_in.shares < s_rd.qty) ? S_EX_RD : S_RM_RD;
                end else if (not_found) begin
                    n_state = S_PRICE;
                end
            end
            S_EX_RD: n_state = S_EX_WR;
            S_EX_WR: begin
                lvl_we = 1'b1;
                lvl_wd = '{orders: lv_rd.orders, total: lv_rd.total - TOT_W'(r_in.shares)};
                slot_we = 1'b1;
                slot_wd.qty = r_ent.qty - r_in.shares;
                n_state = S_PRICE;
            end
            S_RM_RD: n_state = S_RM_WR;
            S_RM_WR: begin
                lvl_we = 1'b1;
                lvl_wd = '{orders: rm_orders, total: lv_rd.total - TOT_W'(r_ent.qty)};
                slot_we = 1'b1;
                slot_wd.valid = 1'b0;
                stk_we = 1'b1;
                if (rm_empty) begin
                    occ_we = 1'b1;
                    occ_wd = occ_rd & ~lvl_bit;
                end
                if (rm_best) n_state = S_SCAN_RD;
                else n_state = post_rm_pick ? S_PICK : S_PRICE;
            end
            S_SCAN_RD: begin
                occ_ra  = r_sw;
                n_state = S_SCAN_CK;
            end
            S_SCAN_CK: begin
                if (scan_hit || (r_sdn && r_sw == '0) ||
                    (!r_sdn && r_sw == WIDX_W'(NWORDS - 1))) begin
                    n_state = post_rm_pick ? S_PICK : S_PRICE;
                end else begin
                    n_state = S_SCAN_RD;
                end
            end
            S_PICK: n_state = pick_ok ? S_POP : S_PRICE;
            S_POP: n_state = S_PL_RD;
            S_PL_RD: n_state = S_PL_WR;
            S_PL_WR: begin
                lvl_we = 1'b1;
                lvl_wd = '{orders: lv_rd.orders + ORD_W'(1),
                           total:  lv_rd.total + TOT_W'(r_in.shares)};
                occ_we = 1'b1;
                occ_wd = occ_rd | lvl_bit;
                slot_we = 1'b1;
                slot_wd = '{valid: 1'b1,
                            oref:  (r_in.mode == MODE_REPLACE) ? r_in.new_ref
                                                               : r_in.msg_ref,
                            qty:   r_in.shares,
                            lvl:   r_lvl};
                n_state = S_PRICE;
            end
            S_PRICE: n_state = S_DONE;
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Best-level offsets back to prices
    logic [LVL_W-1:0] ask_off;
    assign ask_off = r_ask_lvl - LVL_W'(WINDOW);

    // Datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr        <= '0;
            r_fc         <= CNT_W'(CAP);
            r_bid_ok     <= 1'b0;
            r_ask_ok     <= 1'b0;
            r_base       <= '0;
            r_base_known <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            // drain the output register; S_DONE reloads it itself
            if (r_out_valid && !i_out_stall && r_state != S_DONE) r_out_valid <= 1'b0;
            case (r_state)
                S_CLEAR: r_clr <= r_clr + CLR_W'(1);
                S_IDLE: begin
                    // hold the transaction for the whole update
                    if (i_in_valid) begin
                        r_in     <= i_in_item;
                        r_status <= ST_OK;
                    end
                end
                S_DIV: begin
                    // whole cents via reciprocal multiply
                    r_q <= Q_W'((64'(r_in.price) * 64'(DIV_RECIP)) >> DIV_SHIFT);
                end
                S_REM: begin
                    r_rem_nz  <= (r_in.price != (32'(r_q) * 32'(PRICE_STEP)));
                    r_side    <= r_in.is_sell;
                    r_scan    <= '0;
                    r_rd_pend <= 1'b0;
                    if (r_in.mode == MODE_ADD && r_fc == '0) r_status <= ST_FULL;
                end
                S_FIND: begin
                    // advance the slot scan one read a cycle
                    r_rd_pend <= (r_scan < CNT_W'(CAP));
                    r_rd_addr <= r_scan[SLOT_W-1:0];
                    if (r_scan < CNT_W'(CAP)) r_scan <= r_scan + CNT_W'(1);
                    if (slot_hit) begin
                        r_ent  <= s_rd;
                        r_slot <= r_rd_addr;
                        r_lvl  <= s_rd.lvl;
                        r_side <= (s_rd.lvl >= LVL_W'(WINDOW));
                    end else if (not_found) begin
                        r_status <= ST_UNKNOWN;
                    end
                end
                S_RM_WR: begin
                    r_fc <= r_fc + CNT_W'(1);
                    if (rm_best) begin
                        r_sw     <= r_lvl[LVL_W-1:6];
                        r_sb     <= r_lvl[5:0];
                        r_sfirst <= 1'b1;
                        r_sdn    <= (r_lvl < LVL_W'(WINDOW));
                    end
                end
                S_SCAN_CK: begin
                    r_sfirst <= 1'b0;
                    if (scan_hit) begin
                        if (r_sdn) r_bid_lvl <= {r_sw, f_top_bit(scan_word)};
                        else r_ask_lvl <= {r_sw, f_low_bit(scan_word)};
                    end else if (r_sdn) begin
                        if (r_sw == '0) r_bid_ok <= 1'b0;
                        else r_sw <= r_sw - WIDX_W'(1);
                    end else begin
                        if (r_sw == WIDX_W'(NWORDS - 1)) r_ask_ok <= 1'b0;
                        else r_sw <= r_sw + WIDX_W'(1);
                    end
                end
                S_PICK: begin
                    // first pick fixes the window even when the price is rejected
                    if (!r_base_known) begin
                        r_base       <= eff_base;
                        r_base_known <= 1'b1;
                    end
                    r_lvl <= pick_lvl;
                    if (!pick_ok) r_status <= ST_RANGE;
                end
                S_PL_RD: r_slot <= stk_rd;
                S_PL_WR: begin
                    r_fc <= r_fc - CNT_W'(1);
                    if (r_lvl < LVL_W'(WINDOW)) begin
                        if (!r_bid_ok || r_lvl > r_bid_lvl) begin
                            r_bid_ok  <= 1'b1;
                            r_bid_lvl <= r_lvl;
                        end
                    end else if (!r_ask_ok || r_lvl < r_ask_lvl) begin
                        r_ask_ok  <= 1'b1;
                        r_ask_lvl <= r_lvl;
                    end
                end
                S_PRICE: begin
                    r_bid_price <= (r_base[31:0] + 32'(r_bid_lvl)) * 32'(PRICE_STEP);
                    r_ask_price <= (r_base[31:0] + 32'(ask_off)) * 32'(PRICE_STEP);
                end
                S_DONE: begin
                    // load the output register once it is free or being drained
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid          <= 1'b1;
                        r_out.status         <= r_status;
                        r_out.bid_valid      <= r_bid_ok;
                        r_out.best_bid_price <= r_bid_ok ? r_bid_price : '0;
                        r_out.ask_valid      <= r_ask_ok;
                        r_out.best_ask_price <= r_ask_ok ? r_ask_price : '0;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

`ifndef SYNTHESIS
    a_fc_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fc <= CNT_W'(CAP)) else $error("free count above capacity");
    a_accept_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> r_state == S_DIV) else $error("accept did not start");
    a_bid_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bid_ok |-> r_bid_lvl < LVL_W'(WINDOW)) else $error("best bid on ask side");
    a_ask_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ask_ok |-> r_ask_lvl >= LVL_W'(WINDOW)) else $error("best ask on bid side");
`endif
endmodule
